### src/aslseq_pkg.sv
// Package for the ADC scan list sequencer.
// Holds list sizing, channel limits and operation codes; no dependencies.
package aslseq_pkg;

	localparam int LIST_DEPTH = 10;
	localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int CNT_W = $clog2(LIST_DEPTH + 1);
	localparam int CH_W = 6;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [CH_W-1:0]  ch_t;

	localparam logic [7:0] CH_LIMIT = 8'd48;
	localparam ch_t GROUP_SPLIT = 6'd32;

	localparam logic [1:0] FUNC_ADD    = 2'd0;
	localparam logic [1:0] FUNC_REMOVE = 2'd1;
	localparam logic [1:0] FUNC_TICK   = 2'd2;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

endpackage

### src/aslseq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; contents are not reset.
module aslseq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic                                         re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### src/adc_scan_list_sequencer.sv
// ADC scan list sequencer: one request in, one result out, channel list in aslseq_ram.
// Add/remove search the list one entry per cycle through the RAM read port and end
// early on a match; tick steps the scan position modulo the list count by repeated
// subtraction. A new request is accepted only once the sequencer is idle and the
// previous result is taken. Reset clears count, scan position and control state;
// list memory is not cleared.
module adc_scan_list_sequencer
	import aslseq_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] func,
	input  logic [7:0] channel,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       list_changed,
	output logic       start_issued,
	output logic       start_group,
	output logic [5:0] start_channel,
	output logic [3:0] list_count
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_ACT,
		ST_MOVE,
		ST_MOD,
		ST_RDW,
		ST_DONE
	} state_t;

	state_t     state_q;
	logic [1:0] func_q;
	logic [7:0] ch_q;
	cnt_t       cnt_q;
	idx_t       pos_q;
	cnt_t       idx_q;
	cnt_t       val_q;
	idx_t       slot_q;
	logic       found_q;
	logic       chg_q;
	logic       iss_q;
	ch_t        sch_q;
	logic       rd_vld_s1;
	idx_t       rd_idx_s1;

	logic       ram_we;
	idx_t       ram_waddr;
	ch_t        ram_wdata;
	logic       ram_re;
	idx_t       ram_raddr;
	ch_t        ram_rdata;

	logic       in_acc;
	logic       issue;
	logic       hit;
	idx_t       last_idx;

	assign in_ready = (state_q == ST_IDLE) && (!out_valid || out_ready);
	assign in_acc   = in_valid && in_ready;
	assign issue    = (idx_q < cnt_q);
	assign hit      = rd_vld_s1 && ({2'b00, ram_rdata} == ch_q);
	assign last_idx = idx_t'(cnt_q - cnt_t'(1));

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		case (state_q)
			ST_SEARCH: begin
				ram_re    = issue;
				ram_raddr = idx_q[IDX_W-1:0];
			end
			ST_ACT: begin
				if (func_q == FUNC_ADD) begin
					ram_we    = !found_q && (cnt_q < cnt_t'(LIST_DEPTH));
					ram_waddr = cnt_q[IDX_W-1:0];
					ram_wdata = ch_q[CH_W-1:0];
				end else begin
					ram_re    = found_q && (slot_q != last_idx);
					ram_raddr = last_idx;
				end
			end
			ST_MOVE: begin
				ram_we    = 1'b1;
				ram_waddr = slot_q;
				ram_wdata = ram_rdata;
			end
			ST_MOD: begin
				ram_re    = (val_q < cnt_q);
				ram_raddr = val_q[IDX_W-1:0];
			end
			default: begin
			end
		endcase
	end

	aslseq_ram #(
		.WIDTH(CH_W),
		.DEPTH(LIST_DEPTH)
	) u_list (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		rd_idx_s1 <= idx_q[IDX_W-1:0];
		if (in_acc) begin
			func_q <= func;
			ch_q   <= channel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cnt_q         <= '0;
			pos_q         <= '0;
			idx_q         <= '0;
			val_q         <= '0;
			slot_q        <= '0;
			found_q       <= 1'b0;
			chg_q         <= 1'b0;
			iss_q         <= 1'b0;
			sch_q         <= '0;
			rd_vld_s1     <= 1'b0;
			out_valid     <= 1'b0;
			list_changed  <= 1'b0;
			start_issued  <= 1'b0;
			start_group   <= 1'b0;
			start_channel <= '0;
			list_count    <= '0;
		end else begin
			rd_vld_s1 <= (state_q == ST_SEARCH) && issue;
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						chg_q   <= 1'b0;
						iss_q   <= 1'b0;
						sch_q   <= '0;
						found_q <= 1'b0;
						idx_q   <= '0;
						val_q   <= cnt_t'(pos_q) + cnt_t'(1);
						if ((func == FUNC_ADD || func == FUNC_REMOVE) &&
							channel < CH_LIMIT) begin
							state_q <= ST_SEARCH;
						end else if (func == FUNC_TICK && cnt_q != '0) begin
							state_q <= ST_MOD;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_SEARCH: begin
					if (issue) begin
						idx_q <= idx_q + cnt_t'(1);
					end
					if (hit) begin
						found_q <= 1'b1;
						slot_q  <= rd_idx_s1;
						state_q <= ST_ACT;
					end else if (!issue && !rd_vld_s1) begin
						state_q <= ST_ACT;
					end
				end
				ST_ACT: begin
					state_q <= ST_DONE;
					if (func_q == FUNC_ADD) begin
						if (!found_q && cnt_q < cnt_t'(LIST_DEPTH)) begin
							cnt_q <= cnt_q + cnt_t'(1);
							chg_q <= 1'b1;
						end
					end else if (found_q) begin
						cnt_q <= cnt_q - cnt_t'(1);
						chg_q <= 1'b1;
						if (slot_q != last_idx) begin
							state_q <= ST_MOVE;
						end
					end
				end
				ST_MOVE: begin
					state_q <= ST_DONE;
				end
				ST_MOD: begin
					if (val_q >= cnt_q) begin
						val_q <= val_q - cnt_q;
					end else begin
						pos_q   <= val_q[IDX_W-1:0];
						state_q <= ST_RDW;
					end
				end
				ST_RDW: begin
					sch_q   <= ram_rdata;
					iss_q   <= 1'b1;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					out_valid     <= 1'b1;
					list_changed  <= chg_q;
					start_issued  <= iss_q;
					start_group   <= (sch_q >= GROUP_SPLIT);
					start_channel <= sch_q;
					list_count    <= 4'(cnt_q);
					state_q       <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= cnt_t'(LIST_DEPTH))
		else $error("list count beyond depth");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("request accepted while busy");

	a_ram_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("list read and write in one cycle");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_DONE))
		else $error("result raised outside done");

	a_tick_changes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && iss_q) |-> !chg_q)
		else $error("tick marked as list change");

endmodule

### sim/adc_scan_list_sequencer_tb.sv
`timescale 1ns / 1ps
// Testbench for adc_scan_list_sequencer: directed and random add/remove/tick requests,
// checked against an in-bench model of the channel list. Depends on aslseq_pkg and the DUT.
module adc_scan_list_sequencer_tb
	import aslseq_pkg::*;
();

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 20;
	localparam int ITEMS_PER_PHASE = 400;

	typedef struct packed {
		logic       list_changed;
		logic       start_issued;
		logic       start_group;
		logic [5:0] start_channel;
		logic [3:0] list_count;
	} scan_result_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [1:0] func = FUNC_ADD;
	logic [7:0] channel = 8'd0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       list_changed;
	logic       start_issued;
	logic       start_group;
	logic [5:0] start_channel;
	logic [3:0] list_count;

	// list model
	ch_t mdl_list [LIST_DEPTH];
	int  mdl_count = 0;
	int  mdl_pos = 0;

	scan_result_t pending_results [$];
	int err_count = 0;
	int req_count = 0;
	int start_count = 0;
	int change_count = 0;
	int idle_cycles = 0;
	int snd_idle = 0;
	int rcv_idle = 0;

	adc_scan_list_sequencer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.channel      (channel),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.list_changed (list_changed),
		.start_issued (start_issued),
		.start_group  (start_group),
		.start_channel(start_channel),
		.list_count   (list_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic scan_result_t predict_scan(logic [1:0] f, logic [7:0] c);
		scan_result_t r;
		bit found;
		int slot;
		r = '0;
		found = 1'b0;
		slot = 0;
		for (int i = 0; i < mdl_count; i++)
			if (!found && {2'b00, mdl_list[i]} == c) begin
				found = 1'b1;
				slot = i;
			end
		case (f)
			FUNC_ADD: begin
				if (c < CH_LIMIT && !found && mdl_count < LIST_DEPTH) begin
					mdl_list[mdl_count] = c[5:0];
					mdl_count++;
					r.list_changed = 1'b1;
				end
			end
			FUNC_REMOVE: begin
				if (c < CH_LIMIT && found) begin
					mdl_count--;
					mdl_list[slot] = mdl_list[mdl_count];
					r.list_changed = 1'b1;
				end
			end
			FUNC_TICK: begin
				if (mdl_count != 0) begin
					mdl_pos = (mdl_pos + 1) % mdl_count;
					r.start_channel = mdl_list[mdl_pos];
					r.start_issued = 1'b1;
					r.start_group = (mdl_list[mdl_pos] >= GROUP_SPLIT);
				end
			end
			default: ;
		endcase
		r.list_count = mdl_count[3:0];
		return r;
	endfunction

	task automatic check_field(string name, int exp_v, int got_v);
		if (exp_v != got_v) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
			err_count++;
		end
	endtask

	// request acceptance feeds the model; result acceptance pops and compares
	always @(posedge clk) begin
		scan_result_t e;
		if (in_valid && in_ready) begin
			e = predict_scan(func, channel);
			pending_results.push_back(e);
			req_count++;
			if (e.start_issued)
				start_count++;
			if (e.list_changed)
				change_count++;
		end
		if (out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with no request outstanding", $time);
				err_count++;
			end else begin
				e = pending_results.pop_front();
				check_field("list_changed", e.list_changed, list_changed);
				check_field("start_issued", e.start_issued, start_issued);
				check_field("start_group", e.start_group, start_group);
				check_field("start_channel", e.start_channel, start_channel);
				check_field("list_count", e.list_count, list_count);
			end
		end
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog expired, %0d results outstanding", $time,
				pending_results.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	always @(negedge clk)
		out_ready <= ($urandom_range(0, 99) >= rcv_idle);

	task automatic send_request(logic [1:0] f, logic [7:0] c);
		@(negedge clk);
		while ($urandom_range(0, 99) < snd_idle) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		func = f;
		channel = c;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	task automatic release_input();
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic wait_drain();
		release_input();
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic test_directed();
		send_request(FUNC_TICK, 8'd0);
		send_request(FUNC_UNUSED, 8'hFF);
		send_request(FUNC_ADD, 8'd0);
		send_request(FUNC_ADD, 8'd47);
		send_request(FUNC_ADD, 8'd48);
		send_request(FUNC_ADD, 8'd255);
		send_request(FUNC_ADD, 8'd0);
		send_request(FUNC_ADD, 8'd31);
		send_request(FUNC_ADD, 8'd32);
		send_request(FUNC_TICK, 8'hFF);
		send_request(FUNC_TICK, 8'd0);
		for (int i = 1; i <= 6; i++)
			send_request(FUNC_ADD, 8'(i));
		send_request(FUNC_ADD, 8'd7);
		send_request(FUNC_TICK, 8'd0);
		send_request(FUNC_REMOVE, 8'd47);
		send_request(FUNC_REMOVE, 8'd47);
		send_request(FUNC_REMOVE, 8'd200);
		send_request(FUNC_REMOVE, 8'd32);
		send_request(FUNC_TICK, 8'd0);
		send_request(FUNC_UNUSED, 8'd0);
		wait_drain();
	endtask

	task automatic test_random(int n);
		int r;
		bit filling;
		logic [1:0] f;
		logic [7:0] c;
		filling = 1'b1;
		for (int k = 0; k < n; k++) begin
			if (k % 40 == 0)
				filling = 1'($urandom_range(0, 1));
			if (k == n / 2)
				wait_drain();
			r = $urandom_range(0, 99);
			c = 8'($urandom_range(0, 47));
			if (r < 6) begin
				f = 2'($urandom_range(0, 3));
				c = (f == FUNC_UNUSED) ? 8'($urandom_range(0, 255)) :
					8'($urandom_range(48, 255));
			end else if (r < 30) begin
				f = FUNC_TICK;
				c = 8'($urandom_range(0, 255));
			end else if ((r < 70) == filling) begin
				f = FUNC_ADD;
				if ($urandom_range(0, 1))
					c = 8'($urandom_range(0, 15));
			end else begin
				f = FUNC_REMOVE;
				if (mdl_count > 0 && $urandom_range(0, 3) != 0)
					c = {2'b00, mdl_list[$urandom_range(0, mdl_count - 1)]};
			end
			send_request(f, c);
		end
		wait_drain();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		snd_idle = 35;
		rcv_idle = 45;
		test_directed();
		test_random(ITEMS_PER_PHASE);

		snd_idle = 45;
		rcv_idle = 35;
		test_random(ITEMS_PER_PHASE);

		snd_idle = 0;
		rcv_idle = 0;
		test_random(ITEMS_PER_PHASE);

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (pending_results.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, pending_results.size());
			err_count += pending_results.size();
		end
		$display("Covered %0d requests: %0d list changes, %0d conversion starts,", req_count,
			change_count, start_count);
		$display("under three sender/receiver stall mixes; %0d mismatches", err_count);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

### sim.f
src/aslseq_pkg.sv
src/aslseq_ram.sv
src/adc_scan_list_sequencer.sv
sim/adc_scan_list_sequencer_tb.sv
